FILE: hw/rtl/tgc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the trilinear grid correction block.
// No dependencies; every other file of the block imports this package.
package tgc_pkg;

    localparam int GRID_X_DEF = 17;
    localparam int GRID_Y_DEF = 17;
    localparam int GRID_Z_DEF = 17;

    // Item kinds on the input channel.
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Scaling: 65536/32000 = 256/125 for x and y, 65536/16000 = 512/125 for z.
    // 256/125 = 2 + 6/125 and 512/125 = 4 + 12/125; the part over 125 uses a
    // reciprocal that is exact for every numerator below 2^24 seen here.
    localparam int XY_OFFSET  = 16000;
    localparam int DIV_BY     = 125;
    localparam int XY_REM_MUL = 6;
    localparam int Z_REM_MUL  = 12;
    localparam int MAG_W      = 21;
    localparam int NUMR_W     = 24;
    localparam int RECIP      = 17179870;
    localparam int RCP_W      = 25;
    localparam int RCP_SHIFT  = 31;
    localparam int QUO_W      = 24;
    localparam int DIV_STEPS  = 2;
    localparam int DCNT_W     = $clog2(DIV_STEPS);

    localparam int FRAC_BITS = 16;
    localparam int IDX_W     = 6;
    localparam int WGT_W     = 18;
    localparam int WXY_W     = 2 * WGT_W;
    localparam int P_W       = 3 * WGT_W;
    localparam int CW_W      = 22;
    localparam int PROD_W    = 16 + CW_W;
    localparam int ACC_W     = PROD_W + 4;
    localparam int WORD_W    = 16;

    localparam int CORNERS   = 8;
    localparam int COMPS     = 3;

    typedef struct packed {
        logic       mem_write;
        logic       load_pos;
        logic       div_step;
        logic       split;
        logic       calc_base;
        logic       issue;
        logic [2:0] corner;
        logic [1:0] comp;
        logic       load_out;
    } tgc_cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } tgc_sts_t;

endpackage

FILE: hw/rtl/tgc_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the trilinear grid correction block: accepts words and steps a query
// through division, split, address and corner reads. Depends on tgc_pkg.
module tgc_ctrl
    import tgc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  logic     s_kind,
    output tgc_cmd_t cmd,
    input  tgc_sts_t sts
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_DIV   = 7'b0000010,
        ST_SPLIT = 7'b0000100,
        ST_BASE  = 7'b0001000,
        ST_ISSUE = 7'b0010000,
        ST_DRAIN = 7'b0100000,
        ST_DONE  = 7'b1000000
    } tgc_state_t;

    tgc_state_t        state_reg, state_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;
    logic [2:0]        corner_reg, corner_next;
    logic [1:0]        comp_reg, comp_next;
    logic              accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next  = state_reg;
        dcnt_next   = dcnt_reg;
        corner_next = corner_reg;
        comp_next   = comp_reg;
        cmd         = '0;
        cmd.corner  = corner_reg;
        cmd.comp    = comp_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_kind == KIND_QUERY) begin
                        cmd.load_pos = 1'b1;
                        dcnt_next    = '0;
                        state_next   = ST_DIV;
                    end else begin
                        cmd.mem_write = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                dcnt_next    = dcnt_reg + 1'b1;
                if (dcnt_reg == DCNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_SPLIT;
                end
            end
            ST_SPLIT: begin
                cmd.split  = 1'b1;
                state_next = ST_BASE;
            end
            ST_BASE: begin
                cmd.calc_base = 1'b1;
                corner_next   = '0;
                comp_next     = '0;
                state_next    = ST_ISSUE;
            end
            ST_ISSUE: begin
                cmd.issue = 1'b1;
                if (comp_reg == 2'(COMPS - 1)) begin
                    comp_next   = '0;
                    corner_next = corner_reg + 1'b1;
                    if (corner_reg == 3'(CORNERS - 1)) begin
                        state_next = ST_DRAIN;
                    end
                end else begin
                    comp_next = comp_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (!sts.pipe_busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            dcnt_reg   <= '0;
            corner_reg <= '0;
            comp_reg   <= '0;
        end else begin
            state_reg  <= state_next;
            dcnt_reg   <= dcnt_next;
            corner_reg <= corner_next;
            comp_reg   <= comp_next;
        end
    end

endmodule

FILE: hw/rtl/tgc_datapath.sv
`timescale 1ns / 1ps
// Datapath of the trilinear grid correction block: grid memory, reciprocal
// position scaling, weight and blend pipeline, output register. Depends on tgc_pkg.
module tgc_datapath
    import tgc_pkg::*;
#(
    parameter int GRID_X = GRID_X_DEF,
    parameter int GRID_Y = GRID_Y_DEF,
    parameter int GRID_Z = GRID_Z_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  tgc_cmd_t           cmd,
    output tgc_sts_t           sts,
    input  logic signed [14:0] s_pos_x,
    input  logic signed [14:0] s_pos_y,
    input  logic signed [14:0] s_pos_z,
    input  logic        [14:0] s_grid_addr,
    input  logic signed [15:0] s_grid_word,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_corr_x,
    output logic signed [15:0] m_corr_y,
    output logic signed [15:0] m_corr_z
);

    localparam int DEPTH    = GRID_X * GRID_Y * GRID_Z * 6;
    localparam int AW       = $clog2(DEPTH);
    localparam int STRIDE_A = GRID_Y * GRID_Z * 6;
    localparam int STRIDE_B = GRID_Z * 6;
    localparam int STRIDE_D = 6;
    localparam int IDX_MAX [3] = '{GRID_X - 2, GRID_Y - 2, GRID_Z - 2};
    localparam int RPROD_W  = NUMR_W + RCP_W;

    // Grid memory, single port.
    logic signed [WORD_W-1:0] word_mem [DEPTH];
    logic signed [WORD_W-1:0] rdata_reg;
    logic [AW-1:0]            raddr;
    logic                     wr_ok;

    assign wr_ok = ({17'd0, s_grid_addr} < 32'(DEPTH));

    always_ff @(posedge aclk) begin
        if (cmd.mem_write && wr_ok) begin
            word_mem[AW'(s_grid_addr)] <= s_grid_word;
        end
        if (cmd.issue) begin
            rdata_reg <= word_mem[raddr];
        end
    end

    // Load magnitudes for the three lanes: x, y, z.
    logic signed [15:0] sx, sy;
    logic signed [31:0] nx, ny;
    logic        [14:0] pz_abs;
    logic        [31:0] nz;
    logic [MAG_W-1:0]   load_mag [3];
    logic               load_neg [3];
    logic               side_in;

    always_comb begin
        sx          = 16'(s_pos_x) + 16'(XY_OFFSET);
        sy          = 16'(s_pos_y) + 16'(XY_OFFSET);
        nx          = 32'(sx) * 32'(GRID_X - 1);
        ny          = 32'(sy) * 32'(GRID_Y - 1);
        pz_abs      = s_pos_z[14] ? 15'(-s_pos_z) : 15'(s_pos_z);
        nz          = 32'(pz_abs) * 32'(GRID_Z - 1);
        load_mag[0] = MAG_W'(nx[31] ? -nx : nx);
        load_mag[1] = MAG_W'(ny[31] ? -ny : ny);
        load_mag[2] = MAG_W'(nz);
        load_neg[0] = nx[31];
        load_neg[1] = ny[31];
        load_neg[2] = 1'b0;
        side_in     = !s_pos_z[14] && (s_pos_z != 15'd0);
    end

    // Two-step scaling: first the remainder numerator, then the reciprocal
    // product added to the whole multiple of the magnitude. A negative lane
    // adds 124 to the numerator so that the negated quotient is a floor.
    logic [MAG_W-1:0]   mag_reg [3];
    logic               neg_reg [3];
    logic               side_reg;
    logic [NUMR_W-1:0]  num_reg [3];
    logic [QUO_W-1:0]   quo_reg [3];
    logic [NUMR_W-1:0]  num_next [3];
    logic [RPROD_W-1:0] rprod [3];
    logic [QUO_W-1:0]   quo_next [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            num_next[k] = NUMR_W'(mag_reg[k])
                          * NUMR_W'((k == 2) ? Z_REM_MUL : XY_REM_MUL)
                          + (neg_reg[k] ? NUMR_W'(DIV_BY - 1) : NUMR_W'(0));
            rprod[k]    = RPROD_W'(num_reg[k]) * RPROD_W'(RECIP);
            quo_next[k] = ((k == 2) ? QUO_W'({mag_reg[k], 2'b00})
                                    : QUO_W'({mag_reg[k], 1'b0}))
                          + QUO_W'(rprod[k] >> RCP_SHIFT);
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < 3; k++) begin
            if (cmd.load_pos) begin
                mag_reg[k] <= load_mag[k];
                neg_reg[k] <= load_neg[k];
            end else if (cmd.div_step) begin
                num_reg[k] <= num_next[k];
                quo_reg[k] <= quo_next[k];
            end
        end
        if (cmd.load_pos) begin
            side_reg <= side_in;
        end
    end

    // Apply the sign, clamp the lower index and take the upper weight.
    logic signed [31:0]      q [3];
    logic signed [31:0]      i_raw [3];
    logic signed [31:0]      i_cl [3];
    logic signed [31:0]      f_full [3];
    logic [IDX_W-1:0]        idx_reg [3];
    logic signed [WGT_W-1:0] frac_reg [3];
    logic signed [WGT_W-1:0] wlo [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            q[k] = signed'(32'(quo_reg[k]));
            if (neg_reg[k]) begin
                q[k] = -q[k];
            end
            i_raw[k] = q[k] >>> FRAC_BITS;
            if (i_raw[k] > 32'(IDX_MAX[k])) begin
                i_cl[k] = 32'(IDX_MAX[k]);
            end else if (i_raw[k] < 0) begin
                i_cl[k] = '0;
            end else begin
                i_cl[k] = i_raw[k];
            end
            f_full[k] = q[k] - (i_cl[k] <<< FRAC_BITS);
            wlo[k]    = WGT_W'(32'sd65536 - 32'(frac_reg[k]));
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.split) begin
            for (int k = 0; k < 3; k++) begin
                idx_reg[k]  <= IDX_W'(i_cl[k]);
                frac_reg[k] <= WGT_W'(f_full[k]);
            end
        end
    end

    // Address of the first word of the lower corner.
    logic [AW-1:0] base_reg;

    always_ff @(posedge aclk) begin
        if (cmd.calc_base) begin
            base_reg <= AW'((((int'(idx_reg[0]) * GRID_Y + int'(idx_reg[1])) * GRID_Z
                             + int'(idx_reg[2])) * 2 + int'(side_reg)) * 3);
        end
    end

    assign raddr = base_reg + AW'((cmd.corner[2] ? STRIDE_A : 0)
                                + (cmd.corner[1] ? STRIDE_B : 0)
                                + (cmd.corner[0] ? STRIDE_D : 0)
                                + int'(cmd.comp));

    // Blend pipeline: x*y weight, times z weight, times word, accumulate.
    logic signed [WXY_W-1:0]  wxy_reg;
    logic signed [P_W-1:0]    p_reg, p_rnd;
    logic signed [WORD_W-1:0] word_reg;
    logic signed [CW_W-1:0]   cw;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg [3];
    logic signed [WGT_W-1:0]  wa, wb, wz_sel;
    logic                     d_s1;
    logic [1:0]               c_s1, c_s2, c_s3;
    logic                     v1_reg, v2_reg, v3_reg;

    always_comb begin
        wa     = cmd.corner[2] ? frac_reg[0] : wlo[0];
        wb     = cmd.corner[1] ? frac_reg[1] : wlo[1];
        wz_sel = d_s1 ? frac_reg[2] : wlo[2];
        p_rnd  = p_reg + (P_W'(1) <<< 31);
        cw     = CW_W'(p_rnd >>> 32);
    end

    always_ff @(posedge aclk) begin
        wxy_reg  <= wa * wb;
        d_s1     <= cmd.corner[0];
        c_s1     <= cmd.comp;
        p_reg    <= wxy_reg * wz_sel;
        word_reg <= rdata_reg;
        c_s2     <= c_s1;
        prod_reg <= word_reg * cw;
        c_s3     <= c_s2;
        if (cmd.calc_base) begin
            for (int k = 0; k < 3; k++) begin
                acc_reg[k] <= '0;
            end
        end else if (v3_reg) begin
            acc_reg[c_s3] <= acc_reg[c_s3] + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Round, saturate and hold the result word.
    logic signed [ACC_W-1:0]  rnd [3];
    logic signed [WORD_W-1:0] sat [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            rnd[k] = (acc_reg[k] + ACC_W'(32768)) >>> FRAC_BITS;
            if (rnd[k] > ACC_W'(32767)) begin
                sat[k] = 16'sh7fff;
            end else if (rnd[k] < -ACC_W'(32768)) begin
                sat[k] = 16'sh8000;
            end else begin
                sat[k] = WORD_W'(rnd[k]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_corr_x <= sat[0];
            m_corr_y <= sat[1];
            m_corr_z <= sat[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    assign sts.pipe_busy = v1_reg || v2_reg || v3_reg;
    assign sts.out_free  = !m_valid || m_ready;

endmodule

FILE: hw/rtl/trilinear_grid_correction_top.sv
`timescale 1ns / 1ps
// Channel  Ports                                  Role
// s_       s_valid/s_ready, kind, pos, addr, word  grid word writes and queries
// m_       m_valid/m_ready, corr_x/y/z             one corrected word per query
//
// Write words are taken back to back while the input is open. A query's result
// word becomes valid once the position is scaled and split, the base address
// is formed, 24 reads of the single-port grid memory (8 corners x 3 components)
// are done, the blend pipeline drains and the output register is loaded. The
// input is closed from acceptance until that load, so queries do not overlap.
// Reset is synchronous, active low; the grid memory is not cleared.
// The output register holds a result word while the next query is computed;
// a finished query waits for that register to be free.
// Top level of the trilinear grid correction block; depends on tgc_pkg,
// tgc_ctrl and tgc_datapath.
module trilinear_grid_correction_top
    import tgc_pkg::*;
#(
    parameter int GRID_X = GRID_X_DEF,
    parameter int GRID_Y = GRID_Y_DEF,
    parameter int GRID_Z = GRID_Z_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_kind,
    input  logic signed [14:0] s_pos_x,
    input  logic signed [14:0] s_pos_y,
    input  logic signed [14:0] s_pos_z,
    input  logic        [14:0] s_grid_addr,
    input  logic signed [15:0] s_grid_word,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_corr_x,
    output logic signed [15:0] m_corr_y,
    output logic signed [15:0] m_corr_z
);

    tgc_cmd_t cmd;
    tgc_sts_t sts;

    tgc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_kind),
        .cmd     (cmd),
        .sts     (sts)
    );

    tgc_datapath #(
        .GRID_X (GRID_X),
        .GRID_Y (GRID_Y),
        .GRID_Z (GRID_Z)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .s_pos_x     (s_pos_x),
        .s_pos_y     (s_pos_y),
        .s_pos_z     (s_pos_z),
        .s_grid_addr (s_grid_addr),
        .s_grid_word (s_grid_word),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_corr_x    (m_corr_x),
        .m_corr_y    (m_corr_y),
        .m_corr_z    (m_corr_z)
    );

endmodule

FILE: hw/rtl/tgc_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the trilinear grid correction block, bound to the top level.
// Depends on tgc_pkg and trilinear_grid_correction_top.
module tgc_port_checks
    import tgc_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               s_kind,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [15:0] m_corr_x,
    input logic signed [15:0] m_corr_y,
    input logic signed [15:0] m_corr_z
);

    // A result word waiting on the output holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_corr_x) && $stable(m_corr_y)
            && $stable(m_corr_z))
        else $error("result word changed while stalled");

    // A write word never produces a result word.
    a_write_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_kind == KIND_WRITE) && !m_valid |=> !m_valid)
        else $error("write word produced a result");

    // A query cannot finish in the cycle after it is accepted.
    a_query_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_kind == KIND_QUERY) && !m_valid |=> !m_valid)
        else $error("query result appeared too early");

    // The input is closed while a query is in flight.
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_kind == KIND_QUERY) |=> !s_ready)
        else $error("input accepted during a query");

endmodule

bind trilinear_grid_correction_top tgc_port_checks u_tgc_port_checks (.*);
